// ===== src/ppt_pkg.sv =====
// Package for the pure pursuit turn radius block.
// Holds fixed-point constants, the arctangent table and shared types.
// No dependencies.
package ppt_pkg;

  localparam int XyW = 40;   // CORDIC x/y width
  localparam int ZW  = 35;   // angle accumulator width, Q.30
  localparam int SW  = 34;   // sine magnitude width
  localparam int NW  = 53;   // divider numerator width, room for ld*2^29 + mag/2
  localparam int QW  = 37;   // radius width

  localparam logic signed [ZW-1:0] PiQ30     = 35'sd3373259426;
  localparam logic signed [ZW-1:0] HalfPiQ30 = 35'sd1686629713;
  localparam logic signed [XyW-1:0] InvGain  = 40'sd652032874;
  localparam logic signed [20:0] PiQ16       = 21'sd205887;
  localparam logic signed [20:0] TwoPiQ16    = 21'sd411775;
  localparam logic [SW-1:0] SinEps           = 34'd1074;
  localparam logic [QW-1:0] RadiusMax        = 37'd65536000000;

  function automatic logic signed [ZW-1:0] atan_q30(input logic [4:0] i);
    case (i)
      5'd0: atan_q30 = 35'sd843314857;  5'd1: atan_q30 = 35'sd497837829;
      5'd2: atan_q30 = 35'sd263043837;  5'd3: atan_q30 = 35'sd133525159;
      5'd4: atan_q30 = 35'sd67021687;   5'd5: atan_q30 = 35'sd33543516;
      5'd6: atan_q30 = 35'sd16775851;   5'd7: atan_q30 = 35'sd8388437;
      5'd8: atan_q30 = 35'sd4194283;    5'd9: atan_q30 = 35'sd2097149;
      5'd31: atan_q30 = 35'sd0;
      default: atan_q30 = ZW'(64'sd1 <<< (30 - i));
    endcase
  endfunction

  typedef struct packed {
    logic signed [XyW-1:0] x;
    logic signed [XyW-1:0] y;
    logic signed [ZW-1:0]  z;
  } cordic_t;

endpackage

// ===== src/ppt_cordic_cell.sv =====
// One CORDIC micro-rotation cell, registered; vectoring or rotation mode.
// Depends on ppt_pkg.
module ppt_cordic_cell import ppt_pkg::*; #(
  parameter int Stage = 0,
  parameter bit Rotate = 1'b0,
  parameter int SideW = 1
) (
  input  logic             clk,
  input  logic             en,
  input  cordic_t          d_in,
  input  logic [SideW-1:0] side_in,
  output cordic_t          d_out,
  output logic [SideW-1:0] side_out
);

  logic up;
  cordic_t nxt;

  always_comb begin
    up = Rotate ? (d_in.z >= 0) : (d_in.y < 0);
    if (up) begin
      nxt.x = d_in.x - (d_in.y >>> Stage);
      nxt.y = d_in.y + (d_in.x >>> Stage);
      nxt.z = d_in.z - atan_q30(5'(Stage));
    end else begin
      nxt.x = d_in.x + (d_in.y >>> Stage);
      nxt.y = d_in.y - (d_in.x >>> Stage);
      nxt.z = d_in.z + atan_q30(5'(Stage));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_out <= nxt;
      side_out <= side_in;
    end
  end

endmodule

// ===== src/ppt_div_cell.sv =====
// One restoring-division cell: one quotient bit per stage, registered.
// Depends on ppt_pkg.
module ppt_div_cell import ppt_pkg::*; #(
  parameter int SideW = 1
) (
  input  logic             clk,
  input  logic             en,
  input  logic [NW-1:0]    rem_in,
  input  logic [NW-1:0]    num_in,
  input  logic [SW-1:0]    den_in,
  input  logic [SideW-1:0] side_in,
  output logic [NW-1:0]    rem_out,
  output logic [NW-1:0]    num_out,
  output logic [SW-1:0]    den_out,
  output logic [SideW-1:0] side_out
);

  logic [NW:0] trial;

  always_comb trial = {rem_in, num_in[NW-1]} - {{(NW+1-SW){1'b0}}, den_in};

  always_ff @(posedge clk) begin
    if (en) begin
      // shift in quotient bit at the bottom of num
      rem_out  <= trial[NW] ? {rem_in[NW-2:0], num_in[NW-1]} : trial[NW-1:0];
      num_out  <= {num_in[NW-2:0], ~trial[NW]};
      den_out  <= den_in;
      side_out <= side_in;
    end
  end

endmodule

// ===== src/pure_pursuit_turn_radius.sv =====
// Pure pursuit turn radius: atan2 by vectoring CORDIC, sine by rotation CORDIC,
// radius by a restoring divider, all as chains of registered cells.
// Throughput one item per cycle while the output is not held; the whole
// pipe stalls together when the output is held, with one skid-free output
// register. Reset clears the valid bits only.
module pure_pursuit_turn_radius import ppt_pkg::*; #(
  parameter int CORDIC_STAGES = 24
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic signed [31:0]  target_x,
  input  logic signed [31:0]  target_y,
  input  logic signed [31:0]  pos_x,
  input  logic signed [31:0]  pos_y,
  input  logic signed [18:0]  heading,
  input  logic [22:0]         lookahead,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [QW-1:0] radius,
  output logic                near_straight
);

  localparam int N = CORDIC_STAGES;
  localparam int Depth = 2 * N + NW + 4;

  logic en;
  logic [Depth-1:0] vld;
  assign en = !out_valid || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (en) vld <= {vld[Depth-2:0], in_valid};
  end
  assign out_valid = vld[Depth-1];

  // stage 0: differences and pre-rotation
  cordic_t v0;
  logic [41:0] s0;   // heading 19, lookahead 23
  logic zero0;
  always_ff @(posedge clk) begin
    logic signed [32:0] dx, dy;
    if (en) begin
      dx = 33'(target_x) - 33'(pos_x);
      dy = 33'(target_y) - 33'(pos_y);
      if (dx < 0) begin
        v0.x <= -XyW'(dx);
        v0.y <= -XyW'(dy);
        v0.z <= (dy >= 0) ? PiQ30 : -PiQ30;
      end else begin
        v0.x <= XyW'(dx);
        v0.y <= XyW'(dy);
        v0.z <= '0;
      end
      zero0 <= (dx == 0) && (dy == 0);
      s0 <= {heading, lookahead};
    end
  end

  cordic_t va [N+1];
  logic [42:0] sa [N+1];
  assign va[0] = v0;
  assign sa[0] = {zero0, s0};
  for (genvar i = 0; i < N; i++) begin : g_vec
    ppt_cordic_cell #(.Stage(i), .Rotate(1'b0), .SideW(43)) u_cell (
      .clk, .en, .d_in(va[i]), .side_in(sa[i]), .d_out(va[i+1]), .side_out(sa[i+1])
    );
  end

  // bearing, wrap, fold
  cordic_t r0;
  logic [22:0] ld1;
  always_ff @(posedge clk) begin
    logic signed [ZW-1:0] zr;
    logic signed [20:0] brg, al;
    logic signed [ZW-1:0] a;
    if (en) begin
      zr  = (va[N].z + ZW'(8192)) >>> 14;
      brg = sa[N][42] ? '0 : 21'(zr);
      al  = brg - 21'(signed'(sa[N][41:23]));
      if (al > PiQ16) al = al - TwoPiQ16;
      else if (al < -PiQ16) al = al + TwoPiQ16;
      a = ZW'(al) <<< 14;
      if (a > HalfPiQ30) a = PiQ30 - a;
      else if (a < -HalfPiQ30) a = -PiQ30 - a;
      r0.x <= InvGain;
      r0.y <= '0;
      r0.z <= a;
      ld1 <= sa[N][22:0];
    end
  end

  cordic_t ra [N+1];
  logic [22:0] la [N+1];
  assign ra[0] = r0;
  assign la[0] = ld1;
  for (genvar i = 0; i < N; i++) begin : g_rot
    ppt_cordic_cell #(.Stage(i), .Rotate(1'b1), .SideW(23)) u_cell (
      .clk, .en, .d_in(ra[i]), .side_in(la[i]), .d_out(ra[i+1]), .side_out(la[i+1])
    );
  end

  // divider setup: numerator ld*2^29 + mag/2
  logic [NW-1:0] num0;
  logic [SW-1:0] den0;
  logic [1:0] f0;   // {straight, negative}
  always_ff @(posedge clk) begin
    logic [SW-1:0] mag;
    if (en) begin
      mag = ra[N].y < 0 ? SW'(-ra[N].y) : SW'(ra[N].y);
      den0 <= (mag < SinEps) ? SW'(1) : mag;
      num0 <= NW'({la[N], 29'd0}) + NW'(mag >> 1);
      f0 <= {mag < SinEps, ra[N].y < 0};
    end
  end

  logic [NW-1:0] rm [NW+1];
  logic [NW-1:0] nm [NW+1];
  logic [SW-1:0] dn [NW+1];
  logic [1:0]    fl [NW+1];
  assign rm[0] = '0;
  assign nm[0] = num0;
  assign dn[0] = den0;
  assign fl[0] = f0;
  for (genvar i = 0; i < NW; i++) begin : g_div
    ppt_div_cell #(.SideW(2)) u_cell (
      .clk, .en, .rem_in(rm[i]), .num_in(nm[i]), .den_in(dn[i]), .side_in(fl[i]),
      .rem_out(rm[i+1]), .num_out(nm[i+1]), .den_out(dn[i+1]), .side_out(fl[i+1])
    );
  end

  always_ff @(posedge clk) begin
    logic [QW-1:0] q;
    if (en) begin
      q = (nm[NW] > NW'(RadiusMax)) ? RadiusMax : QW'(nm[NW]);
      if (fl[NW][1]) begin
        radius <= signed'(RadiusMax);
        near_straight <= 1'b1;
      end else begin
        radius <= fl[NW][0] ? -signed'(q) : signed'(q);
        near_straight <= 1'b0;
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) !en |=> $stable(vld))
    else $error("pipe moved while stalled");
  assert property (@(posedge clk) disable iff (rst) out_valid && near_straight |-> radius > 0)
    else $error("straight result not positive");
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (radius <= signed'(RadiusMax)) && (radius >= -signed'(RadiusMax)))
    else $error("radius beyond saturation");

endmodule

// ===== dv/tb_pure_pursuit_turn_radius.sv =====
// Testbench for pure_pursuit_turn_radius: directed and random items against a
// bit-exact turn radius predictor, with random idling on both channels.
// Depends on ppt_pkg and the pure_pursuit_turn_radius RTL.
module tb_pure_pursuit_turn_radius;
  import ppt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Stages  = 24;
  localparam int Latency = 2 * Stages + 56;

  typedef struct {
    logic [QW-1:0] radius;
    logic          straight;
  } radius_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic signed [31:0]    target_x = '0;
  logic signed [31:0]    target_y = '0;
  logic signed [31:0]    pos_x = '0;
  logic signed [31:0]    pos_y = '0;
  logic signed [18:0]    heading = '0;
  logic [22:0]           lookahead = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic signed [QW-1:0]  radius;
  logic                  near_straight;

  radius_t expected_radii[$];
  int      fail_count = 0;
  bit      quiet = 1'b0;

  longint arctan_tab[32] = '{
    843314857, 497837829, 263043837, 133525159, 67021687, 33543516, 16775851,
    8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072, 65536, 32768,
    16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2, 1, 0};

  pure_pursuit_turn_radius #(.CORDIC_STAGES(Stages)) uut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #5ms;
    $display("FAIL");
    $finish;
  end

  function automatic longint bearing_q16(longint dx, longint dy);
    longint x, y, z, nx;
    x = dx;
    y = dy;
    z = 0;
    if (dx == 0 && dy == 0) return 0;
    // turn a left-half vector by pi first
    if (dx < 0) begin
      x = -dx;
      y = -dy;
      z = (dy >= 0) ? 64'sd3373259426 : -64'sd3373259426;
    end
    for (int i = 0; i < Stages; i++) begin
      if (y >= 0) begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        z += arctan_tab[i];
      end else begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        z -= arctan_tab[i];
      end
      x = nx;
    end
    return (z + 8192) >>> 14;
  endfunction

  function automatic longint sine_q30(longint alpha);
    longint a, x, y, nx;
    a = alpha * 16384;
    x = 652032874;
    y = 0;
    if (a > 64'sd1686629713) a = 64'sd3373259426 - a;
    else if (a < -64'sd1686629713) a = -64'sd3373259426 - a;
    for (int i = 0; i < Stages; i++) begin
      if (a >= 0) begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        a -= arctan_tab[i];
      end else begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        a += arctan_tab[i];
      end
      x = nx;
    end
    return y;
  endfunction

  function automatic radius_t turn_radius(logic signed [31:0] tx, logic signed [31:0] ty,
                                          logic signed [31:0] px, logic signed [31:0] py,
                                          logic signed [18:0] hd, logic [22:0] ld);
    longint alpha, s, mag, q;
    radius_t res;
    alpha = bearing_q16(longint'(tx) - longint'(px), longint'(ty) - longint'(py))
            - longint'(hd);
    if (alpha > 205887) alpha -= 411775;
    else if (alpha < -205887) alpha += 411775;
    s = sine_q30(alpha);
    mag = (s < 0) ? -s : s;
    if (mag < 1074) begin
      res.radius = 37'd65536000000;
      res.straight = 1'b1;
    end else begin
      q = (longint'(ld) * (64'sd1 <<< 29) + mag / 2) / mag;
      if (q > 64'sd65536000000) q = 64'sd65536000000;
      res.radius = QW'((s < 0) ? -q : q);
      res.straight = 1'b0;
    end
    return res;
  endfunction

  task automatic send_item(logic signed [31:0] tx, logic signed [31:0] ty,
                           logic signed [31:0] px, logic signed [31:0] py,
                           logic signed [18:0] hd, logic [22:0] ld);
    if (!quiet && $urandom_range(99) < 20) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    target_x  <= tx;
    target_y  <= ty;
    pos_x     <= px;
    pos_y     <= py;
    heading   <= hd;
    lookahead <= ld;
    in_valid  <= 1'b1;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
    expected_radii.push_back(turn_radius(tx, ty, px, py, hd, ld));
  endtask

  always @(posedge clk) begin
    if (rst) out_ready <= 1'b0;
    else out_ready <= quiet || ($urandom_range(99) >= 17);
  end

  always @(negedge clk) begin
    radius_t exp_r;
    if (!rst && out_valid && out_ready) begin
      if (expected_radii.size() == 0) begin
        $display("%t: unexpected item radius=%0d straight=%b", $realtime, radius,
                 near_straight);
        fail_count++;
      end else begin
        exp_r = expected_radii.pop_front();
        if (radius !== exp_r.radius) begin
          $display("%t: radius expected %0d actual %0d", $realtime,
                   $signed(exp_r.radius), radius);
          fail_count++;
        end
        if (near_straight !== exp_r.straight) begin
          $display("%t: near_straight expected %b actual %b", $realtime,
                   exp_r.straight, near_straight);
          fail_count++;
        end
      end
    end
  end

  task automatic test_directed();
    // straight ahead: tiny sine
    send_item(32'sd65536, 0, 0, 0, 0, 23'd4194304);
    // zero offset
    send_item(32'sd1000, 32'sd2000, 32'sd1000, 32'sd2000, 19'sd1000, 23'd65536);
    // target behind, dy zero, negative and positive
    send_item(-32'sd65536, 0, 0, 0, 0, 23'd131072);
    send_item(-32'sd65536, -32'sd5, 0, 0, 0, 23'd131072);
    send_item(-32'sd65536, 32'sd5, 0, 0, 19'sd205887, 23'd131072);
    // field extremes, widest offsets
    send_item(32'sh7fffffff, 32'sh7fffffff, 32'sh80000000, 32'sh80000000, 19'sh3ffff,
              23'h7fffff);
    send_item(32'sh80000000, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff, 19'sh40000, 0);
    send_item(32'sh80000000, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000, -19'sd205887,
              23'd4194304);
    send_item(32'sh7fffffff, 32'sh80000000, 0, 0, 19'sd205887, 23'h7fffff);
    // left and right turns, long look-ahead saturating
    send_item(0, 32'sd65536, 0, 0, 0, 23'd65536);
    send_item(0, -32'sd65536, 0, 0, 0, 23'd65536);
    send_item(32'sd65536, 32'sd1, 0, 0, 0, 23'h7fffff);
    send_item(32'sd65536, 32'sd65536, 0, 0, -19'sd102943, 23'd4194304);
    send_item(-32'sd65536, -32'sd65536, 0, 0, 19'sd205887, 23'd1);
    send_item(32'sd300000, -32'sd65536, 32'sd10, 32'sd10, 19'sh3ffff, 23'd3000000);
  endtask

  task automatic test_random(int count);
    logic signed [31:0] tx, ty, px, py;
    logic signed [18:0] hd;
    logic [22:0] ld;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(99) < 60) begin
        // realistic geometry near the vehicle
        px = $signed($urandom_range(0, 20000000)) - 10000000;
        py = $signed($urandom_range(0, 20000000)) - 10000000;
        tx = px + $signed($urandom_range(0, 8388608)) - 4194304;
        ty = py + $signed($urandom_range(0, 8388608)) - 4194304;
        hd = 19'($signed($urandom_range(0, 411774)) - 205887);
        ld = 23'($urandom_range(0, 4194304));
      end else begin
        tx = $urandom;
        ty = $urandom;
        px = $urandom;
        py = $urandom;
        hd = 19'($urandom);
        ld = 23'($urandom);
      end
      send_item(tx, ty, px, py, hd, ld);
    end
  endtask

  task automatic test_back_to_back(int count);
    quiet = 1'b1;
    test_random(count);
    quiet = 1'b0;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(400);
    test_back_to_back(150);
    test_random(300);
    in_valid <= 1'b0;
    while (expected_radii.size() != 0) @(posedge clk);
    repeat (Latency + 20) @(posedge clk);
    if (fail_count == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end
endmodule
